[design/lobm_pkg.sv]
// Shared types and constants for the limit order book matcher.
package lobm_pkg;

    localparam int BOOK_DEPTH_DEFAULT = 64;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_CANCEL = 1'b1;

    localparam logic KIND_TRADE  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] order_id;
        logic        is_buy;
        logic [31:0] limit_price;
        logic [23:0] order_qty;
    } command_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] resting_id;
        logic [31:0] aggressor_id;
        logic        aggressor_buy;
        logic [31:0] trade_price;
        logic [23:0] trade_size;
        logic        last;
    } result_t;

    // One book slot as held in the slot RAM.
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] price;
        logic        buy;
        logic [23:0] remaining;
        logic [31:0] arrival;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

[design/lobm_stream_if.sv]
// Valid/ready stream interface carrying one payload.
interface lobm_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/lobm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

[design/limit_order_book_matcher.sv]
// Limit order book matcher: sequencer, slot valid bits and one shared compare unit.
//
//  channel | dir | payload   | meaning
//  cmd     | in  | command_t | add limit order or cancel by id
//  res     | out | result_t  | trade or book-full rejection, last flags end
//
// A cancel is one id scan through the slot RAM read port.
// An add runs the same id scan, then best-order scans until it is filled or no
// crossing order is left, then the free-slot search; each best-order scan reads one slot per cycle.
// Reset clears the slot valid bits and the arrival counter at once; no clearing pass.
// Results wait in a one-deep hold and an output register; a stalled sink holds
// the sequencer only when a new result must move forward.
module limit_order_book_matcher #(
    parameter int BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    lobm_stream_if.sink   cmd,
    lobm_stream_if.source res
);
    localparam int IW = $clog2(BOOK_DEPTH);
    localparam int CW = $clog2(BOOK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(BOOK_DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_IDSCAN = 6'b000010,
        ST_BSCAN  = 6'b000100,
        ST_FILL   = 6'b001000,
        ST_FREE   = 6'b010000,
        ST_FLUSH  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [BOOK_DEPTH-1:0] valid_reg, valid_next;
    logic [31:0]           arrival_reg, arrival_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         n_reg, n_next;
    lobm_pkg::command_t    cmd_reg, cmd_next;
    logic [23:0]           rem_reg, rem_next;
    logic                  best_found_reg, best_found_next;
    logic [IW-1:0]         best_idx_reg, best_idx_next;
    lobm_pkg::entry_t      best_reg, best_next;
    logic [31:0]           best_age_reg, best_age_next;
    logic                  pend_valid_reg, pend_valid_next;
    lobm_pkg::result_t     pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;
    lobm_pkg::result_t     out_reg, out_next;

    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    lobm_pkg::entry_t      wr_entry;
    logic [IW-1:0]         rd_addr;
    logic [lobm_pkg::ENTRY_W-1:0] rd_raw;
    lobm_pkg::entry_t      rd_entry;

    logic [IW-1:0] prev_idx;
    logic          out_free;
    logic [31:0]   age;
    logic          crosses, better;
    logic [23:0]   fill, slot_left, rem_left;
    lobm_pkg::result_t trade;

    assign rd_entry = lobm_pkg::entry_t'(rd_raw);
    assign rd_addr  = cnt_reg[IW-1:0];
    assign prev_idx = IW'(cnt_reg - CW'(1));
    assign out_free = !out_valid_reg || res.ready;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    lobm_ram #(
        .WIDTH (lobm_pkg::ENTRY_W),
        .DEPTH (BOOK_DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    // Shared compare unit: candidate slot against best so far
    always_comb
    begin
        age     = arrival_reg - rd_entry.arrival;
        crosses = valid_reg[prev_idx] && (rd_entry.buy != cmd_reg.is_buy) &&
                  (cmd_reg.is_buy ? (rd_entry.price <= cmd_reg.limit_price)
                                  : (rd_entry.price >= cmd_reg.limit_price));
        better  = !best_found_reg ||
                  (cmd_reg.is_buy ? (rd_entry.price < best_reg.price)
                                  : (rd_entry.price > best_reg.price)) ||
                  ((rd_entry.price == best_reg.price) && (age > best_age_reg));
    end

    // Fill arithmetic for the selected resting order
    always_comb
    begin
        fill      = (best_reg.remaining < rem_reg) ? best_reg.remaining : rem_reg;
        slot_left = best_reg.remaining - fill;
        rem_left  = rem_reg - fill;
        trade               = '0;
        trade.kind          = lobm_pkg::KIND_TRADE;
        trade.resting_id    = best_reg.id;
        trade.aggressor_id  = cmd_reg.order_id;
        trade.aggressor_buy = cmd_reg.is_buy;
        trade.trade_price   = best_reg.price;
        trade.trade_size    = fill;
        trade.last          = 1'b0;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        arrival_next    = arrival_reg;
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        cmd_next        = cmd_reg;
        rem_next        = rem_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        best_age_next   = best_age_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_next        = out_reg;
        wr_en           = 1'b0;
        wr_addr         = best_idx_reg;
        wr_entry        = best_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next        = cmd.data;
                    rem_next        = cmd.data.order_qty;
                    cnt_next        = '0;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDSCAN;
                end
            end

            // Look for the command's id among resting orders
            ST_IDSCAN:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg != '0 && valid_reg[prev_idx] &&
                    rd_entry.id == cmd_reg.order_id)
                begin
                    if (cmd_reg.opcode == lobm_pkg::OP_CANCEL)
                    begin
                        valid_next[prev_idx] = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
                else if (cnt_reg == DEPTH_C)
                begin
                    cnt_next        = '0;
                    best_found_next = 1'b0;
                    if (cmd_reg.opcode == lobm_pkg::OP_CANCEL || rem_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_BSCAN;
                    end
                end
            end

            // Best crossing resting order, one slot per cycle
            ST_BSCAN:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg != '0 && crosses && better)
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = prev_idx;
                    best_next       = rd_entry;
                    best_age_next   = age;
                end
                if (cnt_reg == DEPTH_C)
                begin
                    cnt_next = '0;
                    if (best_found_next)
                    begin
                        state_next = ST_FILL;
                    end
                    else if (rem_reg != '0)
                    begin
                        state_next = ST_FREE;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            // Apply one fill; the previous trade moves out as not last
            ST_FILL:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                    end
                    pend_valid_next    = 1'b1;
                    pend_next          = trade;
                    wr_en              = 1'b1;
                    wr_entry.remaining = slot_left;
                    if (slot_left == '0)
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                    end
                    rem_next        = rem_left;
                    n_next          = n_reg + CW'(1);
                    cnt_next        = '0;
                    best_found_next = 1'b0;
                    if (rem_left == '0)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else if (n_next == DEPTH_C)
                    begin
                        state_next = ST_FREE;
                    end
                    else
                    begin
                        state_next = ST_BSCAN;
                    end
                end
            end

            // Lowest free slot for the remainder, else reject unless the fills reached BOOK_DEPTH
            ST_FREE:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (!valid_reg[cnt_reg[IW-1:0]])
                begin
                    wr_en              = 1'b1;
                    wr_addr            = cnt_reg[IW-1:0];
                    wr_entry.id        = cmd_reg.order_id;
                    wr_entry.price     = cmd_reg.limit_price;
                    wr_entry.buy       = cmd_reg.is_buy;
                    wr_entry.remaining = rem_reg;
                    wr_entry.arrival   = arrival_reg;
                    valid_next[cnt_reg[IW-1:0]] = 1'b1;
                    arrival_next = arrival_reg + 32'd1;
                    state_next   = ST_FLUSH;
                end
                else if (cnt_reg == DEPTH_C - CW'(1))
                begin
                    if (n_reg != DEPTH_C)
                    begin
                        pend_valid_next         = 1'b1;
                        pend_next               = '0;
                        pend_next.kind          = lobm_pkg::KIND_REJECT;
                        pend_next.aggressor_id  = cmd_reg.order_id;
                        pend_next.aggressor_buy = cmd_reg.is_buy;
                        pend_next.trade_price   = cmd_reg.limit_price;
                        pend_next.trade_size    = rem_reg;
                    end
                    state_next = ST_FLUSH;
                end
            end

            // Final result goes out flagged last
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            arrival_reg    <= '0;
            cnt_reg        <= '0;
            n_reg          <= '0;
            best_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            arrival_reg    <= arrival_next;
            cnt_reg        <= cnt_next;
            n_reg          <= n_next;
            best_found_reg <= best_found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        rem_reg      <= rem_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        best_age_reg <= best_age_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end
endmodule

[design/lobm_checker.sv]
// Port-level checks for the limit order book matcher, bound to the top level.
module lobm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input logic              res_valid,
    input logic              res_ready,
    input lobm_pkg::result_t res_data
);
    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // One command at a time: busy right after a request is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("second request taken while busy");

    // A rejection is always flagged last and carries no resting id
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.kind == lobm_pkg::KIND_REJECT |->
            res_data.last && res_data.resting_id == 32'd0)
        else $error("malformed rejection");

    // Trades never carry zero size
    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.kind == lobm_pkg::KIND_TRADE |->
            res_data.trade_size != 24'd0)
        else $error("zero size trade");
endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);

[tb/limit_order_book_matcher_tb.sv]
// Testbench for the limit order book matcher: directed and random requests, scoreboarded results.
module limit_order_book_matcher_tb;

    localparam int DEPTH = 64;
    localparam int STALL_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lobm_stream_if #(.payload_t(lobm_pkg::command_t)) cmd_if ();
    lobm_stream_if #(.payload_t(lobm_pkg::result_t))  res_if ();

    limit_order_book_matcher #(.BOOK_DEPTH(DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if.sink),
        .res   (res_if.source)
    );

    always #5 clk = ~clk;

    // Book copy used to work out the expected trades
    logic        bk_valid [DEPTH];
    logic [31:0] bk_id    [DEPTH];
    logic [31:0] bk_price [DEPTH];
    logic        bk_buy   [DEPTH];
    logic [23:0] bk_rem   [DEPTH];
    logic [31:0] bk_arr   [DEPTH];
    logic [31:0] arrival_seq;

    lobm_pkg::command_t pending_cmds [$];
    lobm_pkg::result_t  expected_fills [$];
    int       errors = 0;
    bit       stim_done = 0;
    bit       quiet_tail = 0;
    bit       hold_off = 0;
    bit       cmd_acc = 0;
    int       cmd_gap = 0;
    int       res_gap = 0;
    int       idle_cycles = 0;

    function automatic int find_order(logic [31:0] id);
        for (int i = 0; i < DEPTH; i++)
            if (bk_valid[i] && bk_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int best_contra(logic buy, logic [31:0] lim);
        int best;
        logic [31:0] p;
        best = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (!bk_valid[i] || bk_buy[i] == buy)
                continue;
            p = bk_price[i];
            if (buy ? (p > lim) : (p < lim))
                continue;
            if (best < 0)
                best = i;
            else if (buy ? (p < bk_price[best]) : (p > bk_price[best]))
                best = i;
            else if (p == bk_price[best] &&
                     (arrival_seq - bk_arr[i]) > (arrival_seq - bk_arr[best]))
                best = i;
        end
        return best;
    endfunction

    // Apply one accepted request to the book, queue the trades or rejection it causes
    task automatic match_request(lobm_pkg::command_t c);
        lobm_pkg::result_t r;
        logic [23:0] rem, fill;
        int n, b, f;
        n = 0;
        rem = c.order_qty;
        if (c.opcode == lobm_pkg::OP_CANCEL) begin
            b = find_order(c.order_id);
            if (b >= 0)
                bk_valid[b] = 1'b0;
            return;
        end
        if (find_order(c.order_id) >= 0 || rem == 0)
            return;
        while (rem > 0 && n < DEPTH) begin
            b = best_contra(c.is_buy, c.limit_price);
            if (b < 0)
                break;
            fill = (bk_rem[b] < rem) ? bk_rem[b] : rem;
            bk_rem[b] -= fill;
            rem -= fill;
            r = '{lobm_pkg::KIND_TRADE, bk_id[b], c.order_id, c.is_buy, bk_price[b],
                  fill, 1'b0};
            expected_fills = {expected_fills, r};
            n++;
            if (bk_rem[b] == 0)
                bk_valid[b] = 1'b0;
        end
        if (rem > 0) begin
            f = -1;
            for (int i = 0; i < DEPTH; i++)
                if (!bk_valid[i] && f < 0)
                    f = i;
            if (f >= 0) begin
                bk_valid[f] = 1'b1;
                bk_id[f]    = c.order_id;
                bk_price[f] = c.limit_price;
                bk_buy[f]   = c.is_buy;
                bk_rem[f]   = rem;
                bk_arr[f]   = arrival_seq;
                arrival_seq++;
            end else if (n < DEPTH) begin
                r = '{lobm_pkg::KIND_REJECT, 32'd0, c.order_id, c.is_buy, c.limit_price,
                      rem, 1'b0};
                expected_fills = {expected_fills, r};
                n++;
            end
        end
        if (n > 0)
            expected_fills[$].last = 1'b1;
    endtask

    function automatic lobm_pkg::command_t mk_add(logic [31:0] id, logic buy,
                                                  logic [31:0] p, logic [23:0] q);
        return '{lobm_pkg::OP_ADD, id, buy, p, q};
    endfunction

    task automatic enqueue_cmd(lobm_pkg::command_t c);
        pending_cmds = {pending_cmds, c};
    endtask

    // Driver: requests change on the falling edge
    always @(negedge clk) begin
        if (!rst_n) begin
            cmd_if.valid <= 1'b0;
            cmd_if.data  <= '0;
        end else if (cmd_if.valid && !cmd_acc) begin
            // hold until taken
        end else if (cmd_gap > 0) begin
            cmd_gap <= cmd_gap - 1;
            cmd_if.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
            cmd_if.data  <= pending_cmds.pop_front();
            cmd_if.valid <= 1'b1;
            if (!quiet_tail && $urandom_range(0, 5) == 0)
                cmd_gap <= $urandom_range(1, 10);
        end else begin
            cmd_if.valid <= 1'b0;
        end
    end

    // Receiver backpressure
    always @(negedge clk) begin
        if (!rst_n || quiet_tail) begin
            res_if.ready <= !hold_off && rst_n;
            res_gap <= 0;
        end else if (hold_off) begin
            res_if.ready <= 1'b0;
        end else if (res_gap > 0) begin
            res_gap <= res_gap - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
                res_gap <= $urandom_range(1, 10);
        end
    end

    // Request taken at the last rising edge
    always @(posedge clk) begin
        cmd_acc <= rst_n && cmd_if.valid && cmd_if.ready;
    end

    // Monitor: prediction on accepted requests, compare accepted results
    always @(posedge clk) begin
        if (rst_n) begin
            if (cmd_if.valid && cmd_if.ready)
                match_request(cmd_if.data);
            if (res_if.valid && res_if.ready) begin
                if (expected_fills.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, res_if.data);
                    errors++;
                end else if (res_if.data !== expected_fills[0]) begin
                    $display("%0t: mismatch expected %p actual %p", $time,
                             expected_fills[0], res_if.data);
                    errors++;
                    void'(expected_fills.pop_front());
                end else begin
                    void'(expected_fills.pop_front());
                end
            end
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog
    always @(posedge clk) begin
        if (idle_cycles > STALL_LIMIT) begin
            $display("FAIL limit_order_book_matcher");
            $finish;
        end
    end

    // Long receiver hold-off during the sweep, while the sender keeps offering
    initial begin
        wait (rst_n);
        do
            @(posedge clk);
        while (!(cmd_if.valid && cmd_if.ready &&
                 cmd_if.data.opcode == lobm_pkg::OP_ADD &&
                 cmd_if.data.order_id == 32'h201));
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    initial begin
        lobm_pkg::command_t c;
        int n_ids;
        for (int i = 0; i < DEPTH; i++)
            bk_valid[i] = 1'b0;
        arrival_seq = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, partial and multi fills, duplicate, zero qty, cancels
        enqueue_cmd(mk_add(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 24'hFF_FFFF));
        enqueue_cmd(mk_add(32'd0, 1'b0, 32'd0, 24'd1));
        enqueue_cmd(mk_add(32'd1, 1'b0, 32'd100, 24'd5));
        enqueue_cmd(mk_add(32'd2, 1'b0, 32'd100, 24'd5));
        enqueue_cmd(mk_add(32'd1, 1'b1, 32'd100, 24'd9));
        enqueue_cmd(mk_add(32'd3, 1'b1, 32'hFFFF_FFFF, 24'd12));
        enqueue_cmd(mk_add(32'd4, 1'b1, 32'd50, 24'd0));
        enqueue_cmd(mk_add(32'd5, 1'b1, 32'd99, 24'd3));
        enqueue_cmd(mk_add(32'd6, 1'b0, 32'd0, 24'hFF_FFFF));
        enqueue_cmd('{lobm_pkg::OP_CANCEL, 32'h1234_5678, 1'b1, 32'hFFFF_FFFF,
                      24'hFF_FFFF});
        enqueue_cmd('{lobm_pkg::OP_CANCEL, 32'd6, 1'b0, 32'd0, 24'd0});
        enqueue_cmd('{lobm_pkg::OP_CANCEL, 32'hFFFF_FFFF, 1'b0, 32'd0, 24'd0});
        // Fill the book completely, then provoke a rejection
        for (int i = 0; i < DEPTH + 1; i++)
            enqueue_cmd(mk_add(32'h100 + i, 1'b1, 32'd10, 24'd1));
        enqueue_cmd(mk_add(32'h200, 1'b1, 32'd10, 24'd7));
        // Sweep many resting orders with one large sell
        enqueue_cmd(mk_add(32'h201, 1'b0, 32'd0, 24'hFF_FFFF));
        enqueue_cmd('{lobm_pkg::OP_CANCEL, 32'h201, 1'b0, 32'd0, 24'd0});

        // Random: small id pool to hit duplicates and cancels, clustered prices
        for (int k = 0; k < 80; k++) begin
            n_ids = $urandom_range(0, 9) == 0 ? 0 : 1;
            c.opcode      = ($urandom_range(0, 4) == 0) ? lobm_pkg::OP_CANCEL
                                                        : lobm_pkg::OP_ADD;
            c.order_id    = n_ids ? $urandom_range(0, 80) : $urandom;
            c.is_buy      = 1'($urandom_range(0, 1));
            c.limit_price = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(95, 105);
            c.order_qty   = ($urandom_range(0, 9) == 0) ? 24'($urandom)
                                                        : 24'($urandom_range(0, 20));
            if (k >= 65)
                quiet_tail = 1'b1;
            enqueue_cmd(c);
            if (k == 60)
                wait (pending_cmds.size() < 10);
        end
        quiet_tail = 1'b1;
        wait (pending_cmds.size() == 0 && !cmd_if.valid);
        wait (expected_fills.size() == 0);
        repeat (400) @(posedge clk);
        if (errors == 0 && expected_fills.size() == 0)
            $display("PASS limit_order_book_matcher");
        else
            $display("FAIL limit_order_book_matcher");
        $finish;
    end
endmodule

[sim.f]
design/lobm_pkg.sv
design/lobm_stream_if.sv
design/lobm_ram.sv
design/limit_order_book_matcher.sv
design/lobm_checker.sv
tb/limit_order_book_matcher_tb.sv
